/* sv/heading_maneuver_sequencer_assert.svh */
// ----------------------------------------------------------------------------
// Heading maneuver sequencer assertion macros
// Shared property wrappers for the sequencer's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef HEADING_MANEUVER_SEQUENCER_ASSERT_SVH
`define HEADING_MANEUVER_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HMS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heading maneuver sequencer check failed");

// next-cycle implication, checked out of reset
`define HMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heading maneuver sequencer check failed");

`endif

/* sv/hms_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hms_pkg
// Types, codes and reset constants of the heading maneuver sequencer.
// ----------------------------------------------------------------------------
package hms_pkg;

    typedef enum logic [2:0] {
        MAN_STRAIGHT = 3'd0,
        MAN_REVERSE  = 3'd1,
        MAN_LEFTQ    = 3'd2,
        MAN_RIGHTQ   = 3'd3,
        MAN_NUDGE_L  = 3'd4,
        MAN_NUDGE_R  = 3'd5
    } t_maneuver;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BUSY    = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    // item kinds
    localparam logic FUNC_CMD    = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // command codes
    localparam logic [2:0] CMD_UP      = 3'd0;
    localparam logic [2:0] CMD_DOWN    = 3'd1;
    localparam logic [2:0] CMD_LEFT    = 3'd2;
    localparam logic [2:0] CMD_RIGHT   = 3'd3;
    localparam logic [2:0] CMD_NUDGE_L = 3'd4;
    localparam logic [2:0] CMD_NUDGE_R = 3'd5;

    // headings
    localparam logic [1:0] HDG_UP    = 2'd0;
    localparam logic [1:0] HDG_DOWN  = 2'd1;
    localparam logic [1:0] HDG_LEFT  = 2'd2;
    localparam logic [1:0] HDG_RIGHT = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_STRAIGHT_DIST = 3'd0;
    localparam logic [2:0] REG_REVERSE_DIST  = 3'd1;
    localparam logic [2:0] REG_QUARTER_DIST  = 3'd2;
    localparam logic [2:0] REG_NUDGE_DIST    = 3'd3;
    localparam logic [2:0] REG_STRAIGHT_SPD  = 3'd4;
    localparam logic [2:0] REG_TURNING_SPD   = 3'd5;
    localparam logic [2:0] REG_DUTY_SCALE    = 3'd6;

    // register reset values
    localparam logic [15:0] RST_STRAIGHT_DIST = 16'd2000;
    localparam logic [15:0] RST_REVERSE_DIST  = 16'd1060;
    localparam logic [15:0] RST_QUARTER_DIST  = 16'd615;
    localparam logic [15:0] RST_NUDGE_DIST    = 16'd60;
    localparam logic [6:0]  RST_STRAIGHT_SPD  = 7'd35;
    localparam logic [6:0]  RST_TURNING_SPD   = 7'd70;
    localparam logic [7:0]  RST_DUTY_SCALE    = 8'd20;

    localparam logic [15:0] TICK_MAX = 16'hFFFF;

    // maneuver for a target heading given the current heading
    function automatic t_maneuver pick_maneuver(input logic [1:0] target,
                                                input logic [1:0] heading);
        t_maneuver m;
        m = MAN_STRAIGHT;
        if (target == heading) begin
            m = MAN_STRAIGHT;
        end else begin
            unique case (target)
                HDG_UP: begin
                    m = (heading == HDG_DOWN) ? MAN_REVERSE :
                        (heading == HDG_LEFT) ? MAN_RIGHTQ : MAN_LEFTQ;
                end
                HDG_DOWN: begin
                    m = (heading == HDG_UP)   ? MAN_REVERSE :
                        (heading == HDG_LEFT) ? MAN_LEFTQ : MAN_RIGHTQ;
                end
                HDG_LEFT: begin
                    m = (heading == HDG_UP)   ? MAN_LEFTQ :
                        (heading == HDG_DOWN) ? MAN_RIGHTQ : MAN_REVERSE;
                end
                default: begin
                    m = (heading == HDG_UP)   ? MAN_RIGHTQ :
                        (heading == HDG_DOWN) ? MAN_LEFTQ : MAN_REVERSE;
                end
            endcase
        end
        return m;
    endfunction

endpackage

/* sv/heading_maneuver_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_maneuver_sequencer
// Two-wheel maneuver sequencer: command and encoder beats in, drive beats out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries command beats (tuser 0) and encoder sample beats (tuser 1).
//   A command taken while idle starts a maneuver and sets both wheel duties and
//   directions; sample beats add left-encoder ticks until the maneuver's
//   distance is reached, which stops the wheels and flags done with the tag.
//   Every accepted beat yields exactly one m_axis beat with the drive state
//   after it, plus busy, done, heading and status.
//   A beat passes through the input register, then through the update logic
//   into the result register. Throughput is one beat per cycle while m_axis
//   does not stall; the result register frees up the same cycle its beat is
//   taken, so s_axis_tready follows m_axis_tready.
//   When m_axis stalls, the result holds, one more beat waits in the input
//   register, and then s_axis_tready drops.
//   The cfg channel is always ready; write it only while no beat is in flight.
//   Reset (synchronous, active low) empties both registers, sets heading up,
//   idle, zero ticks, and loads the default distances, speeds and scale.
// ----------------------------------------------------------------------------
module heading_maneuver_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input beats
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // cmd_code[2:0], seq_tag[18:3], left_delta[34:19]
    input  logic [0:0]  s_axis_tuser,   // func[0]
    // result beats
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // left_duty[14:0], left_fwd[15], right_duty[30:16],
                                        // right_fwd[31], busy_res[32], done_res[33],
                                        // done_tag[49:34], heading_now[51:50], status[53:52]
);

    // configuration registers
    logic [15:0] r_straight_dist, r_reverse_dist, r_quarter_dist, r_nudge_dist;
    logic [6:0]  r_straight_spd, r_turning_spd;
    logic [7:0]  r_duty_scale;

    // input register
    logic        r_in_valid;
    logic        r_in_func;
    logic [2:0]  r_in_code;
    logic [15:0] r_in_tag;
    logic [15:0] r_in_delta;

    // sequencer state
    logic [1:0]        r_heading, n_heading;
    logic              r_active, n_active;
    hms_pkg::t_maneuver r_maneuver, n_maneuver;
    logic [2:0]        r_target, n_target;
    logic [15:0]       r_pending_tag, n_pending_tag;
    logic [15:0]       r_tick_total, n_tick_total;

    // result register
    logic        r_out_valid;
    logic [14:0] r_out_left_duty, n_out_left_duty;
    logic        r_out_left_fwd, n_out_left_fwd;
    logic [14:0] r_out_right_duty, n_out_right_duty;
    logic        r_out_right_fwd, n_out_right_fwd;
    logic        r_out_done, n_out_done;
    logic [15:0] r_out_done_tag, n_out_done_tag;
    hms_pkg::t_status r_out_status, n_out_status;

    // heading and busy are sampled into the result register alongside the rest
    logic [1:0] r_out_heading;
    logic       r_out_busy;

    logic advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_status, r_out_heading, r_out_done_tag, r_out_done,
                            r_out_busy, r_out_right_fwd, r_out_right_duty, r_out_left_fwd,
                            r_out_left_duty};

    // ---------------------------------------------------------------- update
    always_comb begin
        logic [16:0] sum;
        logic [15:0] span;
        logic        check;
        logic        finish;
        logic [14:0] duty;
        logic [6:0]  speed;

        n_heading     = r_heading;
        n_active      = r_active;
        n_maneuver    = r_maneuver;
        n_target      = r_target;
        n_pending_tag = r_pending_tag;
        n_tick_total  = r_tick_total;
        n_out_status  = hms_pkg::ST_OK;
        check         = 1'b0;
        finish        = 1'b0;
        sum           = {1'b0, r_tick_total} + {1'b0, r_in_delta};

        if (r_in_func == hms_pkg::FUNC_CMD) begin
            if (r_active) begin
                n_out_status = hms_pkg::ST_BUSY;
            end else if (r_in_code > hms_pkg::CMD_NUDGE_R) begin
                n_out_status = hms_pkg::ST_INVALID;
            end else begin
                n_target      = r_in_code;
                n_pending_tag = r_in_tag;
                n_tick_total  = '0;
                n_active      = 1'b1;
                check         = 1'b1;
                if (r_in_code == hms_pkg::CMD_NUDGE_L) begin
                    n_maneuver = hms_pkg::MAN_NUDGE_L;
                end else if (r_in_code == hms_pkg::CMD_NUDGE_R) begin
                    n_maneuver = hms_pkg::MAN_NUDGE_R;
                end else begin
                    n_maneuver = hms_pkg::pick_maneuver(r_in_code[1:0], r_heading);
                end
            end
        end else if (r_active) begin
            // saturate the tick total
            n_tick_total = sum[16] ? hms_pkg::TICK_MAX : sum[15:0];
            check        = 1'b1;
        end

        unique case (n_maneuver)
            hms_pkg::MAN_STRAIGHT: span = r_straight_dist;
            hms_pkg::MAN_REVERSE:  span = r_reverse_dist;
            hms_pkg::MAN_LEFTQ,
            hms_pkg::MAN_RIGHTQ:   span = r_quarter_dist;
            default:               span = r_nudge_dist;
        endcase

        // only a start or a counted sample can end the maneuver
        if (check && (n_tick_total >= span)) begin
            finish   = 1'b1;
            n_active = 1'b0;
            if (n_maneuver != hms_pkg::MAN_NUDGE_L && n_maneuver != hms_pkg::MAN_NUDGE_R) begin
                n_heading = n_target[1:0];
            end
        end

        n_out_done     = finish;
        n_out_done_tag = finish ? n_pending_tag : '0;

        speed = (n_maneuver == hms_pkg::MAN_STRAIGHT) ? r_straight_spd : r_turning_spd;
        duty  = 15'(speed * r_duty_scale);

        if (!n_active) begin
            n_out_left_duty  = '0;
            n_out_left_fwd   = 1'b0;
            n_out_right_duty = '0;
            n_out_right_fwd  = 1'b0;
        end else begin
            n_out_left_duty  = duty;
            n_out_right_duty = duty;
            if (n_maneuver == hms_pkg::MAN_STRAIGHT) begin
                n_out_left_fwd  = 1'b1;
                n_out_right_fwd = 1'b1;
            end else if (n_maneuver == hms_pkg::MAN_LEFTQ ||
                         n_maneuver == hms_pkg::MAN_NUDGE_L) begin
                n_out_left_fwd  = 1'b0;
                n_out_right_fwd = 1'b1;
            end else begin
                n_out_left_fwd  = 1'b1;
                n_out_right_fwd = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_straight_dist <= hms_pkg::RST_STRAIGHT_DIST;
            r_reverse_dist  <= hms_pkg::RST_REVERSE_DIST;
            r_quarter_dist  <= hms_pkg::RST_QUARTER_DIST;
            r_nudge_dist    <= hms_pkg::RST_NUDGE_DIST;
            r_straight_spd  <= hms_pkg::RST_STRAIGHT_SPD;
            r_turning_spd   <= hms_pkg::RST_TURNING_SPD;
            r_duty_scale    <= hms_pkg::RST_DUTY_SCALE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                hms_pkg::REG_STRAIGHT_DIST: r_straight_dist <= i_cfg_data;
                hms_pkg::REG_REVERSE_DIST:  r_reverse_dist  <= i_cfg_data;
                hms_pkg::REG_QUARTER_DIST:  r_quarter_dist  <= i_cfg_data;
                hms_pkg::REG_NUDGE_DIST:    r_nudge_dist    <= i_cfg_data;
                hms_pkg::REG_STRAIGHT_SPD:  r_straight_spd  <= i_cfg_data[6:0];
                hms_pkg::REG_TURNING_SPD:   r_turning_spd   <= i_cfg_data[6:0];
                hms_pkg::REG_DUTY_SCALE:    r_duty_scale    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        // hold the beat until it moves on
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_func  <= s_axis_tuser[0];
            r_in_code  <= s_axis_tdata[2:0];
            r_in_tag   <= s_axis_tdata[18:3];
            r_in_delta <= s_axis_tdata[34:19];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading     <= hms_pkg::HDG_UP;
            r_active      <= 1'b0;
            r_maneuver    <= hms_pkg::MAN_STRAIGHT;
            r_target      <= hms_pkg::CMD_UP;
            r_pending_tag <= '0;
            r_tick_total  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (advance) begin
                r_heading     <= n_heading;
                r_active      <= n_active;
                r_maneuver    <= n_maneuver;
                r_target      <= n_target;
                r_pending_tag <= n_pending_tag;
                r_tick_total  <= n_tick_total;
                r_out_valid   <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_out_left_duty  <= n_out_left_duty;
            r_out_left_fwd   <= n_out_left_fwd;
            r_out_right_duty <= n_out_right_duty;
            r_out_right_fwd  <= n_out_right_fwd;
            r_out_busy       <= n_active;
            r_out_done       <= n_out_done;
            r_out_done_tag   <= n_out_done_tag;
            r_out_heading    <= n_heading;
            r_out_status     <= n_out_status;
        end
    end

    // ----------------------------------------------------------- assertions
`include "heading_maneuver_sequencer_assert.svh"

    `HMS_ASSERT_SAME(a_done_stops, i_clk, i_rst_n, r_out_valid && r_out_done,
        !r_out_busy && r_out_left_duty == '0 && r_out_right_duty == '0)
    `HMS_ASSERT_NEXT(a_busy_tracks_state, i_clk, i_rst_n, advance,
        r_out_busy == r_active && r_out_heading == r_heading)
    `HMS_ASSERT_NEXT(a_cmd_while_busy, i_clk, i_rst_n,
        advance && r_active && r_in_func == hms_pkg::FUNC_CMD,
        r_out_status == hms_pkg::ST_BUSY && r_active)
    `HMS_ASSERT_NEXT(a_nudge_keeps_heading, i_clk, i_rst_n,
        advance && r_active && (r_maneuver == hms_pkg::MAN_NUDGE_L ||
                                r_maneuver == hms_pkg::MAN_NUDGE_R),
        $stable(r_heading))

endmodule

/* test/tb_heading_maneuver_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heading_maneuver_sequencer
// Self-checking bench for the heading maneuver sequencer. A short table of
// directed command and encoder beats walks every maneuver, the busy, invalid,
// zero-distance and saturation corners, then randomized phases with different
// register settings run well-formed command/sample sequences mixed with noise.
// A behavioral copy of the sequencer predicts each result beat; results are
// compared field by field in order while both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_heading_maneuver_sequencer;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_PAUSE = 4;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 110;
    localparam int PRINT_CAP   = 40;

    // result beat, last field first so the layout matches m_axis_tdata
    typedef struct packed {
        hms_pkg::t_status status;
        logic [1:0]  heading;
        logic [15:0] done_tag;
        logic        done;
        logic        busy;
        logic        rfwd;
        logic [14:0] rduty;
        logic        lfwd;
        logic [14:0] lduty;
    } t_drive_beat;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // for register rows, code holds the index and tag the data
    typedef struct packed {
        t_row_kind   kind;
        logic        func;
        logic [2:0]  code;
        logic [15:0] tag;
        logic [15:0] delta;
        logic        typed;
        t_drive_beat want;
    } t_plan_row;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index   = '0;
    logic [15:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;  // cmd_code[2:0], seq_tag[18:3], left_delta[34:19]
    logic [0:0]  s_axis_tuser  = '0;  // func[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // left_duty[14:0], left_fwd[15], right_duty[30:16],
                                      // right_fwd[31], busy_res[32], done_res[33],
                                      // done_tag[49:34], heading_now[51:50], status[53:52]

    // sequencer copy: registers
    logic [15:0] straight_dist = hms_pkg::RST_STRAIGHT_DIST;
    logic [15:0] reverse_dist  = hms_pkg::RST_REVERSE_DIST;
    logic [15:0] quarter_dist  = hms_pkg::RST_QUARTER_DIST;
    logic [15:0] nudge_dist    = hms_pkg::RST_NUDGE_DIST;
    logic [6:0]  straight_spd  = hms_pkg::RST_STRAIGHT_SPD;
    logic [6:0]  turning_spd   = hms_pkg::RST_TURNING_SPD;
    logic [7:0]  duty_scale    = hms_pkg::RST_DUTY_SCALE;

    // sequencer copy: state
    logic [1:0]         hdg       = hms_pkg::HDG_UP;
    logic               running   = 1'b0;
    hms_pkg::t_maneuver cur_man   = hms_pkg::MAN_STRAIGHT;
    logic [2:0]         goal_code = '0;
    logic [15:0]        held_tag  = '0;
    logic [15:0]        ticks     = '0;

    t_drive_beat drive_q[$];
    t_plan_row   plan[$];
    int          mismatches     = 0;
    int          src_gap_pct    = 30;
    int          sink_stall_pct = 30;

    heading_maneuver_sequencer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic t_drive_beat beat(input int lduty, input int lfwd,
                                         input int rduty, input int rfwd,
                                         input int busy, input int done,
                                         input int tag, input int heading,
                                         input hms_pkg::t_status status);
        t_drive_beat b;
        b.lduty    = 15'(lduty);
        b.lfwd     = 1'(lfwd);
        b.rduty    = 15'(rduty);
        b.rfwd     = 1'(rfwd);
        b.busy     = 1'(busy);
        b.done     = 1'(done);
        b.done_tag = 16'(tag);
        b.heading  = 2'(heading);
        b.status   = status;
        return b;
    endfunction

    function automatic t_plan_row item_row(input logic func, input logic [2:0] code,
                                           input logic [15:0] tag, input logic [15:0] delta);
        t_plan_row r;
        r       = '0;
        r.kind  = ROW_ITEM;
        r.func  = func;
        r.code  = code;
        r.tag   = tag;
        r.delta = delta;
        return r;
    endfunction

    function automatic t_plan_row checked_row(input logic func, input logic [2:0] code,
                                              input logic [15:0] tag, input logic [15:0] delta,
                                              input t_drive_beat want);
        t_plan_row r;
        r       = item_row(func, code, tag, delta);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic t_plan_row reg_row(input logic [2:0] index, input logic [15:0] data);
        t_plan_row r;
        r      = '0;
        r.kind = ROW_CFG;
        r.code = index;
        r.tag  = data;
        return r;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    function automatic logic [15:0] leg_span(input hms_pkg::t_maneuver m);
        case (m)
            hms_pkg::MAN_STRAIGHT: return straight_dist;
            hms_pkg::MAN_REVERSE:  return reverse_dist;
            hms_pkg::MAN_LEFTQ,
            hms_pkg::MAN_RIGHTQ:   return quarter_dist;
            default:               return nudge_dist;
        endcase
    endfunction

    function automatic void apply_reg(input logic [2:0] index, input logic [15:0] data);
        case (index)
            hms_pkg::REG_STRAIGHT_DIST: straight_dist = data;
            hms_pkg::REG_REVERSE_DIST:  reverse_dist  = data;
            hms_pkg::REG_QUARTER_DIST:  quarter_dist  = data;
            hms_pkg::REG_NUDGE_DIST:    nudge_dist    = data;
            hms_pkg::REG_STRAIGHT_SPD:  straight_spd  = data[6:0];
            hms_pkg::REG_TURNING_SPD:   turning_spd   = data[6:0];
            hms_pkg::REG_DUTY_SCALE:    duty_scale    = data[7:0];
            default: ;
        endcase
    endfunction

    // advance the sequencer copy by one beat and return the drive state after it
    function automatic t_drive_beat advance_sequencer(input logic func, input logic [2:0] code,
                                                      input logic [15:0] tag,
                                                      input logic [15:0] delta);
        t_drive_beat r;
        logic        moved;
        logic [16:0] sum;
        logic [6:0]  spd;
        r     = '0;
        moved = 1'b0;
        if (func == hms_pkg::FUNC_CMD) begin
            if (running) begin
                r.status = hms_pkg::ST_BUSY;
            end else if (code > hms_pkg::CMD_NUDGE_R) begin
                r.status = hms_pkg::ST_INVALID;
            end else begin
                goal_code = code;
                held_tag  = tag;
                ticks     = '0;
                if (code == hms_pkg::CMD_NUDGE_L) begin
                    cur_man = hms_pkg::MAN_NUDGE_L;
                end else if (code == hms_pkg::CMD_NUDGE_R) begin
                    cur_man = hms_pkg::MAN_NUDGE_R;
                end else if (code[1:0] == hdg) begin
                    cur_man = hms_pkg::MAN_STRAIGHT;
                end else if ((code[1:0] ^ hdg) == 2'b01) begin
                    // up/down and left/right differ only in bit 0: opposite headings
                    cur_man = hms_pkg::MAN_REVERSE;
                end else begin
                    case ({code[1:0], hdg})
                        {hms_pkg::HDG_UP, hms_pkg::HDG_RIGHT},
                        {hms_pkg::HDG_DOWN, hms_pkg::HDG_LEFT},
                        {hms_pkg::HDG_LEFT, hms_pkg::HDG_UP},
                        {hms_pkg::HDG_RIGHT, hms_pkg::HDG_DOWN}: cur_man = hms_pkg::MAN_LEFTQ;
                        default:                                 cur_man = hms_pkg::MAN_RIGHTQ;
                    endcase
                end
                running = 1'b1;
                moved   = 1'b1;
            end
        end else if (running) begin
            sum   = {1'b0, ticks} + {1'b0, delta};
            ticks = sum[16] ? hms_pkg::TICK_MAX : sum[15:0];
            moved = 1'b1;
        end

        if (moved && ticks >= leg_span(cur_man)) begin
            running = 1'b0;
            if (cur_man != hms_pkg::MAN_NUDGE_L && cur_man != hms_pkg::MAN_NUDGE_R)
                hdg = goal_code[1:0];
            r.done     = 1'b1;
            r.done_tag = held_tag;
        end

        if (running) begin
            spd     = (cur_man == hms_pkg::MAN_STRAIGHT) ? straight_spd : turning_spd;
            r.lduty = spd * duty_scale;
            r.rduty = r.lduty;
            r.lfwd  = !(cur_man == hms_pkg::MAN_LEFTQ || cur_man == hms_pkg::MAN_NUDGE_L);
            r.rfwd  = (cur_man == hms_pkg::MAN_STRAIGHT || cur_man == hms_pkg::MAN_LEFTQ ||
                       cur_man == hms_pkg::MAN_NUDGE_L);
        end
        r.busy    = running;
        r.heading = hdg;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (mismatches < PRINT_CAP)
            $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // drop valid and hold until every pending result beat is back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (drive_q.size() != 0);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(index, data);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_regs(input logic [15:0] sd, input logic [15:0] rd,
                                input logic [15:0] qd, input logic [15:0] nd,
                                input logic [6:0] ss, input logic [6:0] ts,
                                input logic [7:0] sc);
        write_reg(hms_pkg::REG_STRAIGHT_DIST, sd);
        write_reg(hms_pkg::REG_REVERSE_DIST, rd);
        write_reg(hms_pkg::REG_QUARTER_DIST, qd);
        write_reg(hms_pkg::REG_NUDGE_DIST, nd);
        write_reg(hms_pkg::REG_STRAIGHT_SPD, {9'd0, ss});
        write_reg(hms_pkg::REG_TURNING_SPD, {9'd0, ts});
        write_reg(hms_pkg::REG_DUTY_SCALE, {8'd0, sc});
    endtask

    task automatic push_item(input logic func, input logic [2:0] code, input logic [15:0] tag,
                             input logic [15:0] delta, input logic typed,
                             input t_drive_beat want);
        t_drive_beat predicted;
        if ($urandom_range(0, 99) < src_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap_len()) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {5'd0, delta, tag, code};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = advance_sequencer(func, code, tag, delta);
        drive_q.push_back(typed ? want : predicted);
    endtask

    // result side: random stalls, some phases without any
    initial begin
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 99) < sink_stall_pct) begin
                m_axis_tready <= 1'b0;
                repeat (gap_len()) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_drive_beat got;
        t_drive_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_drive_beat'(m_axis_tdata[53:0]);
            if (drive_q.size() == 0) begin
                report_mismatch("unexpected beat, done_tag", got.done_tag, '0);
            end else begin
                want = drive_q.pop_front();
                if (got.lduty !== want.lduty) report_mismatch("left_duty", got.lduty, want.lduty);
                if (got.lfwd !== want.lfwd) report_mismatch("left_fwd", got.lfwd, want.lfwd);
                if (got.rduty !== want.rduty)
                    report_mismatch("right_duty", got.rduty, want.rduty);
                if (got.rfwd !== want.rfwd) report_mismatch("right_fwd", got.rfwd, want.rfwd);
                if (got.busy !== want.busy) report_mismatch("busy_res", got.busy, want.busy);
                if (got.done !== want.done) report_mismatch("done_res", got.done, want.done);
                if (got.done_tag !== want.done_tag)
                    report_mismatch("done_tag", got.done_tag, want.done_tag);
                if (got.heading !== want.heading)
                    report_mismatch("heading_now", got.heading, want.heading);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
            end
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        t_plan_row   row;
        int          counted;
        int          pick;
        int          rem;
        logic        func;
        logic [2:0]  code;
        logic [15:0] delta;
        logic        ignored;

        // reset state: idle, heading up, default registers
        plan.push_back(checked_row(hms_pkg::FUNC_SAMPLE, hms_pkg::CMD_UP, 16'h0000, 16'hFFFF,
                                   beat(0, 0, 0, 0, 0, 0, 0, hms_pkg::HDG_UP, hms_pkg::ST_OK)));
        plan.push_back(checked_row(hms_pkg::FUNC_CMD, 3'd7, 16'hFFFF, 16'h0000,
                                   beat(0, 0, 0, 0, 0, 0, 0, hms_pkg::HDG_UP,
                                        hms_pkg::ST_INVALID)));
        plan.push_back(checked_row(hms_pkg::FUNC_CMD, 3'd6, 16'h5A5A, 16'h0000,
                                   beat(0, 0, 0, 0, 0, 0, 0, hms_pkg::HDG_UP,
                                        hms_pkg::ST_INVALID)));
        plan.push_back(checked_row(hms_pkg::FUNC_CMD, hms_pkg::CMD_UP, 16'h1234, 16'h0000,
                                   beat(700, 1, 700, 1, 1, 0, 0, hms_pkg::HDG_UP,
                                        hms_pkg::ST_OK)));
        plan.push_back(checked_row(hms_pkg::FUNC_CMD, hms_pkg::CMD_DOWN, 16'hFFFF, 16'hFFFF,
                                   beat(700, 1, 700, 1, 1, 0, 0, hms_pkg::HDG_UP,
                                        hms_pkg::ST_BUSY)));
        plan.push_back(item_row(hms_pkg::FUNC_SAMPLE, hms_pkg::CMD_UP, 16'h0000, 16'd1999));
        plan.push_back(checked_row(hms_pkg::FUNC_SAMPLE, hms_pkg::CMD_UP, 16'h0000, 16'd1,
                                   beat(0, 0, 0, 0, 0, 1, 16'h1234, hms_pkg::HDG_UP,
                                        hms_pkg::ST_OK)));
        // walk every turn around the compass
        plan.push_back(item_row(hms_pkg::FUNC_CMD, hms_pkg::CMD_DOWN, 16'h0001, 16'h0000));
        plan.push_back(item_row(hms_pkg::FUNC_SAMPLE, hms_pkg::CMD_UP, 16'h0000, 16'hFFFF));
        plan.push_back(item_row(hms_pkg::FUNC_CMD, hms_pkg::CMD_LEFT, 16'h0002, 16'h0000));
        plan.push_back(item_row(hms_pkg::FUNC_SAMPLE, hms_pkg::CMD_UP, 16'h0000, 16'd615));
        plan.push_back(item_row(hms_pkg::FUNC_CMD, hms_pkg::CMD_RIGHT, 16'h0003, 16'h0000));
        plan.push_back(item_row(hms_pkg::FUNC_SAMPLE, hms_pkg::CMD_UP, 16'h0000, 16'hFFFF));
        plan.push_back(item_row(hms_pkg::FUNC_CMD, hms_pkg::CMD_UP, 16'h0004, 16'h0000));
        plan.push_back(item_row(hms_pkg::FUNC_SAMPLE, hms_pkg::CMD_UP, 16'h0000, 16'hFFFF));
        plan.push_back(item_row(hms_pkg::FUNC_CMD, hms_pkg::CMD_RIGHT, 16'h8000, 16'h0000));
        plan.push_back(item_row(hms_pkg::FUNC_SAMPLE, hms_pkg::CMD_UP, 16'h0000, 16'hFFFF));
        plan.push_back(item_row(hms_pkg::FUNC_CMD, hms_pkg::CMD_NUDGE_L, 16'hFFFF, 16'h0000));
        plan.push_back(item_row(hms_pkg::FUNC_SAMPLE, hms_pkg::CMD_UP, 16'h0000, 16'd60));
        plan.push_back(item_row(hms_pkg::FUNC_CMD, hms_pkg::CMD_NUDGE_R, 16'h0000, 16'h0000));
        plan.push_back(item_row(hms_pkg::FUNC_SAMPLE, hms_pkg::CMD_UP, 16'h0000, 16'd100));
        // full-scale duty and a tick total that only finishes by saturating
        plan.push_back(reg_row(hms_pkg::REG_STRAIGHT_DIST, 16'hFFFF));
        plan.push_back(reg_row(hms_pkg::REG_STRAIGHT_SPD, 16'd100));
        plan.push_back(reg_row(hms_pkg::REG_DUTY_SCALE, 16'd255));
        plan.push_back(checked_row(hms_pkg::FUNC_CMD, hms_pkg::CMD_RIGHT, 16'hAAAA, 16'h0000,
                                   beat(25500, 1, 25500, 1, 1, 0, 0, hms_pkg::HDG_RIGHT,
                                        hms_pkg::ST_OK)));
        plan.push_back(item_row(hms_pkg::FUNC_SAMPLE, hms_pkg::CMD_UP, 16'h0000, 16'h8000));
        plan.push_back(checked_row(hms_pkg::FUNC_SAMPLE, hms_pkg::CMD_UP, 16'h0000, 16'h8000,
                                   beat(0, 0, 0, 0, 0, 1, 16'hAAAA, hms_pkg::HDG_RIGHT,
                                        hms_pkg::ST_OK)));
        // zero distance finishes on the command beat itself
        plan.push_back(reg_row(hms_pkg::REG_QUARTER_DIST, 16'h0000));
        plan.push_back(checked_row(hms_pkg::FUNC_CMD, hms_pkg::CMD_UP, 16'h0F0F, 16'h0000,
                                   beat(0, 0, 0, 0, 0, 1, 16'h0F0F, hms_pkg::HDG_UP,
                                        hms_pkg::ST_OK)));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            row = plan[i];
            if (row.kind == ROW_CFG)
                write_reg(row.code, row.tag);
            else
                push_item(row.func, row.code, row.tag, row.delta, row.typed, row.want);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd100, 7'd100, 8'd255);
                1: program_regs(16'd0, 16'd0, 16'd0, 16'd0, 7'd0, 7'd0, 8'd0);
                2: program_regs(hms_pkg::RST_STRAIGHT_DIST, hms_pkg::RST_REVERSE_DIST,
                                hms_pkg::RST_QUARTER_DIST, hms_pkg::RST_NUDGE_DIST,
                                hms_pkg::RST_STRAIGHT_SPD, hms_pkg::RST_TURNING_SPD,
                                hms_pkg::RST_DUTY_SCALE);
                default: program_regs(16'($urandom_range(0, 3000)),
                                      16'($urandom_range(0, 3000)),
                                      16'($urandom_range(0, 3000)),
                                      16'($urandom_range(0, 300)),
                                      7'($urandom_range(0, 100)),
                                      7'($urandom_range(0, 100)),
                                      8'($urandom_range(0, 255)));
            endcase
            src_gap_pct    = (p == 3) ? 0 : (p == 4) ? 60 : 30;
            sink_stall_pct = (p == 3) ? 0 : (p == 4) ? 60 : 30;

            counted = 0;
            while (counted < PHASE_ITEMS) begin
                pick  = $urandom_range(0, 99);
                delta = 16'($urandom);
                if (!running) begin
                    // mostly start a maneuver, sometimes noise
                    func = (pick < 90) ? hms_pkg::FUNC_CMD : hms_pkg::FUNC_SAMPLE;
                    code = (pick < 80) ? 3'($urandom_range(0, 5)) : 3'($urandom_range(6, 7));
                end else begin
                    func = (pick < 8) ? hms_pkg::FUNC_CMD : hms_pkg::FUNC_SAMPLE;
                    code = 3'($urandom_range(0, 7));
                    rem  = int'(leg_span(cur_man)) - int'(ticks);
                    case ($urandom_range(0, 9))
                        0:       ;
                        1:       delta = '0;
                        default: delta = 16'($urandom_range(0, rem));
                    endcase
                end
                ignored = (func == hms_pkg::FUNC_SAMPLE) ? !running : running;
                push_item(func, code, 16'($urandom), delta, 1'b0, '0);
                if (!ignored) counted++;
                if ($urandom_range(0, 199) == 0) settle();
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && drive_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
